/* sv/skvt_pkg.sv */
`default_nettype none
package skvt_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 64;
  localparam int KEY_WIDTH   = 8;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ABSENT  = 2'd1,
    STAT_PRESENT = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // update strobes broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* sv/skvt_cell.sv */
`default_nettype none
module skvt_cell (
  input  wire                                 clk,
  input  wire skvt_pkg::cell_ctrl_t           ctrl,
  input  wire [skvt_pkg::KEY_WIDTH-1:0]       key,
  input  wire                                 live,
  input  wire [skvt_pkg::KEY_WIDTH-1:0]       left_key,
  input  wire [skvt_pkg::VALUE_WIDTH-1:0]     left_value,
  input  wire [skvt_pkg::KEY_WIDTH-1:0]       right_key,
  input  wire [skvt_pkg::VALUE_WIDTH-1:0]     right_value,
  input  wire                                 hit_in,
  input  wire [skvt_pkg::VALUE_WIDTH-1:0]     found_in,
  output logic [skvt_pkg::KEY_WIDTH-1:0]      entry_key,
  output logic [skvt_pkg::VALUE_WIDTH-1:0]    entry_value,
  output logic                                hit_out,
  output logic [skvt_pkg::VALUE_WIDTH-1:0]    found_out
);
  import skvt_pkg::*;

  logic match;

  assign match     = live && (entry_key == key);
  assign hit_out   = hit_in | match;
  // keys are unique, so at most one cell contributes
  assign found_out = found_in | (match ? entry_value : '0);

  // insert shifts the chain toward the tail; remove closes the gap from the
  // matching cell onward by pulling the right neighbor in
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      entry_key   <= left_key;
      entry_value <= left_value;
    end else if (ctrl.remove && hit_out) begin
      entry_key   <= right_key;
      entry_value <= right_value;
    end
  end

endmodule
`default_nettype wire

/* sv/small_key_value_table_top.sv */
// Small key/value table, up to CAPACITY entries of 8-bit key and 64-bit value word.
// Input channel (in_valid/in_stall): command, key, value. One transaction
// in gives exactly one transaction out (out_valid/out_stall): status,
// found_value and entry_count after the operation.
// Entries sit in a chain of cells, packed from cell 0. Every cell compares
// its key in the execute cycle; hit and found value pass cell to cell. An
// insert shifts the chain one place toward the tail, a remove pulls the
// cells from the match onward one place toward the head.
// Timing: a transaction is accepted in S_IDLE, executed in S_EXEC, and its
// result is then written to the output register. No new input transaction
// is taken until the previous one has executed; the accept/execute pair is
// what sets the input rate.
// If the receiver stalls, the result holds in the output register; the next
// transaction can still be accepted but waits in execute until the output
// register is taken.
// Reset (rst, synchronous) empties the table and drops any pending result;
// no clearing pass is needed.
`default_nettype none
module small_key_value_table_top (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [1:0]                            command,
  input  wire [skvt_pkg::KEY_WIDTH-1:0]        key,
  input  wire [63:0]                           value,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [1:0]                           status,
  output logic [63:0]                          found_value,
  output logic [4:0]                           entry_count
);
  import skvt_pkg::*;

  state_t                 state, state_next;
  cmd_t                   cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [CNT_W-1:0]       count, count_next;

  logic                   accept;
  logic                   exec_go;
  logic                   hit;
  logic [VALUE_WIDTH-1:0] hit_value;
  status_t                stat_next;
  logic [VALUE_WIDTH-1:0] found_next;
  cell_ctrl_t             ctrl;

  logic                   chain_hit   [0:CAPACITY];
  logic [VALUE_WIDTH-1:0] chain_found [0:CAPACITY];
  logic [KEY_WIDTH-1:0]   cell_key    [0:CAPACITY-1];
  logic [VALUE_WIDTH-1:0] cell_value  [0:CAPACITY-1];

  // FSM next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall = 1'b1;
    exec_go  = 1'b0;
    case (state)
      S_IDLE:  in_stall = 1'b0;
      S_EXEC:  exec_go  = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd_t'(command);
      key_q   <= key;
      value_q <= VALUE_WIDTH'(value);
    end
  end

  // cell chain
  assign chain_hit[0]   = 1'b0;
  assign chain_found[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   lk, rk;
    logic [VALUE_WIDTH-1:0] lv, rv;
    logic                   live;

    if (i == 0) begin : g_head
      assign lk = key_q;
      assign lv = value_q;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lv = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rk = '0;
      assign rv = '0;
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rv = cell_value[i+1];
    end

    assign live = CNT_W'(i) < count;

    skvt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key_q),
      .live        (live),
      .left_key    (lk),
      .left_value  (lv),
      .right_key   (rk),
      .right_value (rv),
      .hit_in      (chain_hit[i]),
      .found_in    (chain_found[i]),
      .entry_key   (cell_key[i]),
      .entry_value (cell_value[i]),
      .hit_out     (chain_hit[i+1]),
      .found_out   (chain_found[i+1])
    );
  end

  assign hit       = chain_hit[CAPACITY];
  assign hit_value = chain_found[CAPACITY];

  always_comb begin
    ctrl       = '0;
    stat_next  = STAT_OK;
    found_next = '0;
    count_next = count;
    case (cmd_q)
      CMD_LOOKUP: begin
        if (hit) found_next = hit_value;
        else     stat_next  = STAT_ABSENT;
      end
      CMD_INSERT: begin
        if (hit) begin
          stat_next = STAT_PRESENT;
        end else if (count >= CNT_W'(CAPACITY)) begin
          stat_next = STAT_FULL;
        end else begin
          ctrl.insert = exec_go;
          count_next  = CNT_W'(count + 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          ctrl.remove = exec_go;
          count_next  = CNT_W'(count - 1'b1);
        end else begin
          stat_next = STAT_ABSENT;
        end
      end
      default: stat_next = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (exec_go) count <= count_next;
      out_valid <= exec_go || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      status      <= stat_next;
      found_value <= 64'(found_next);
      entry_count <= 5'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> out_valid)
    else $error("executed transaction produced no result");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> count == CNT_W'($past(count) + 1'b1))
    else $error("insert did not grow the table");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctrl.remove |=> count == CNT_W'($past(count) - 1'b1))
    else $error("remove did not shrink the table");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    exec_go && stat_next == STAT_FULL |-> count == CNT_W'(CAPACITY))
    else $error("table full reported while not full");

endmodule
`default_nettype wire
